@@ sv/kdr_pkg.sv @@
`default_nettype none

package kdr_pkg;

    // Block sizing.
    localparam int KEY_COUNT    = 22;
    localparam int REPORT_SLOTS = 8;
    localparam int OUT_FIELDS   = 8;

    // Field and state widths.
    localparam int CONTACT_W  = 22;
    localparam int POS_W      = 16;
    localparam int SLOT_W     = 5;
    localparam int CNT_W      = 11;
    localparam int BAL_W      = 24;
    localparam int HOLD_W     = 15;
    localparam int THR_W      = 10;
    localparam int PHOLD_W    = 14;
    localparam int DIV_W      = 5;
    localparam int LIM_W      = 4;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    // Derived widths.
    localparam int KEY_W      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_CW     = $clog2(KEY_COUNT + 1);
    localparam int SLOT_IDX_W = $clog2(OUT_FIELDS);
    localparam int FILL_W     = $clog2(OUT_FIELDS + 1);
    localparam int DELTA_W    = POS_W + 2;
    localparam int QUOT_W     = POS_W + 1;
    localparam int DCNT_W     = $clog2(POS_W + 1);

    // Encoder unwrap constants.
    localparam logic signed [DELTA_W-1:0] WRAP_LIMIT = DELTA_W'(65000);
    localparam logic signed [DELTA_W-1:0] WRAP_SPAN  = DELTA_W'(65536);

    // Encoder key codes.
    localparam logic [SLOT_W-1:0] CODE_DOWN = SLOT_W'(23);
    localparam logic [SLOT_W-1:0] CODE_UP   = SLOT_W'(24);

    // Register reset values.
    localparam logic [THR_W-1:0]   RST_THRESHOLD = THR_W'(10);
    localparam logic [PHOLD_W-1:0] RST_HOLD      = PHOLD_W'(200);
    localparam logic [DIV_W-1:0]   RST_DIVISOR   = DIV_W'(2);
    localparam logic [LIM_W-1:0]   RST_LIMIT     = LIM_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLD      = 2'd1,
        CFG_DIVISOR   = 2'd2,
        CFG_LIMIT     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACC,
        ST_PULSE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CONTACT_W-1:0] contact_bits;
        logic [POS_W-1:0]     encoder_position;
    } t_frame;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_0;
        logic [SLOT_W-1:0] slot_1;
        logic [SLOT_W-1:0] slot_2;
        logic [SLOT_W-1:0] slot_3;
        logic [SLOT_W-1:0] slot_4;
        logic [SLOT_W-1:0] slot_5;
        logic [SLOT_W-1:0] slot_6;
        logic [SLOT_W-1:0] slot_7;
    } t_report;

endpackage

`default_nettype wire

@@ sv/key_debounce_report_encoder_pulser.sv @@
// Keyboard matrix debounce scanner with an encoder key pulser.
// The input channel (i_in_valid / o_in_ready) takes one scan frame per item:
// the 22 contact bits and the current quadrature counter value. The output
// channel (o_out_valid / i_out_ready) returns one eight-slot key report per
// frame, in order. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) and must only be used while the block is idle.
// After acceptance a frame goes through a walk over the press-counter
// memory, which does one read-modify-write per key per cycle; the encoder
// divider runs alongside that walk. The block takes a new frame in the
// cycle after the previous report was loaded into the output register, so
// it does not start a frame before it is through with the last one.
// Reset clears all press counters (through per-key valid bits), the encoder
// position, balance and hold counter, and loads the register defaults.
// If the receiver stalls, the finished report waits in the output register;
// the next frame is still accepted and processed, and its report waits in
// the slot array until the output register frees up.
`default_nettype none

module key_debounce_report_encoder_pulser (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire kdr_pkg::t_frame                i_in,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output kdr_pkg::t_report                    o_out,
    input  wire                                 i_cfg_we,
    input  wire [kdr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [kdr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import kdr_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]   r_thr;
    logic [PHOLD_W-1:0] r_phold;
    logic [DIV_W-1:0]   r_div;
    logic [LIM_W-1:0]   r_limit;

    // Sequencer.
    t_state r_state, n_state;
    logic   scan_act, acc_act, pulse_act, emit_act;

    // Captured frame.
    logic [CONTACT_W-1:0] r_contacts;
    logic                 r_move;
    logic [POS_W-1:0]     r_last;

    // Press-counter memory, its per-key valid bits and the read pipeline.
    logic [CNT_W-1:0] mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_kvld;
    logic [KEY_CW-1:0]    r_raddr;
    logic [KEY_W-1:0]     raddr;
    logic                 rd_issue;
    logic                 r_rd_vld;
    logic                 r_rd_kv;
    logic [KEY_W-1:0]     r_rd_idx;
    logic [CNT_W-1:0]     r_rd_data;

    // Key processing for the entry coming out of the memory.
    logic [CNT_W-1:0]  cur_cnt, inc_cnt, wr_cnt;
    logic              closed, pressed;
    logic [KEY_W:0]    idx_p1;
    logic [SLOT_W-1:0] key_code;

    // Report being assembled.
    logic [SLOT_W-1:0] r_slots [OUT_FIELDS];
    logic [FILL_W-1:0] r_count;

    // Encoder divider.
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [DELTA_W-1:0] unwrap;
    logic [DELTA_W-1:0]        mag;
    logic                      r_dload;
    logic [DCNT_W-1:0]         r_dcnt;
    logic [POS_W-1:0]          r_dq;
    logic [DIV_W-1:0]          r_rem;
    logic                      r_dneg;
    logic [DIV_W-1:0]          div_eff;
    logic [DIV_W:0]            shifted;
    logic                      q_bit;
    logic                      div_done;

    // Balance and pulser.
    logic signed [BAL_W-1:0]   r_bal;
    logic [HOLD_W-1:0]         r_hold;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [BAL_W:0]     sum;
    logic [LIM_W-1:0]          eff_limit;

    // Output register.
    t_report r_out;
    logic    r_out_vld;
    logic    out_free;

    // ------------------------------------------------------------------
    // Sequencer: next state and decoded controls.
    // ------------------------------------------------------------------
    assign out_free = !r_out_vld || i_out_ready;
    assign div_done = !r_dload && (r_dcnt == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && (r_rd_idx == KEY_W'(KEY_COUNT - 1))) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (div_done) begin
                    n_state = ST_PULSE;
                end
            end
            ST_PULSE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        scan_act   = 1'b0;
        acc_act    = 1'b0;
        pulse_act  = 1'b0;
        emit_act   = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_SCAN:  scan_act   = 1'b1;
            ST_ACC:   acc_act    = div_done;
            ST_PULSE: pulse_act  = 1'b1;
            ST_EMIT:  emit_act   = out_free;
            default:  o_in_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Key walk. A read is issued for one key per cycle; in the cycle after,
    // the counter is updated and written back to the same entry. Each entry is
    // touched once per frame, so reads and writes never collide.
    // ------------------------------------------------------------------
    assign rd_issue = scan_act && (r_raddr < KEY_CW'(KEY_COUNT));
    assign raddr    = r_raddr[KEY_W-1:0];

    always_comb begin
        cur_cnt = r_rd_kv ? r_rd_data : '0;
        closed  = (32'(r_rd_idx) < CONTACT_W) && r_contacts[r_rd_idx];
        if (!closed) begin
            inc_cnt = '0;
        end else if (cur_cnt == '1) begin
            inc_cnt = cur_cnt;
        end else begin
            inc_cnt = cur_cnt + CNT_W'(1);
        end
        pressed  = inc_cnt > CNT_W'(r_thr);
        wr_cnt   = pressed ? (CNT_W'(r_thr) + CNT_W'(1)) : inc_cnt;
        idx_p1   = {1'b0, r_rd_idx} + (KEY_W + 1)'(1);
        key_code = SLOT_W'(idx_p1);
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= mem[raddr];
        end
        if (r_rd_vld) begin
            mem[r_rd_idx] <= wr_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Encoder divider: restoring division of the unwrapped delta magnitude,
    // one quotient bit per cycle.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_delta > WRAP_LIMIT) begin
            unwrap = r_delta - WRAP_SPAN;
        end else if (r_delta < -WRAP_LIMIT) begin
            unwrap = r_delta + WRAP_SPAN;
        end else begin
            unwrap = r_delta;
        end
        mag     = unwrap[DELTA_W-1] ? DELTA_W'(-unwrap) : DELTA_W'(unwrap);
        div_eff = (r_div == '0) ? DIV_W'(1) : r_div;
        shifted = {r_rem, r_dq[POS_W-1]};
        q_bit   = shifted >= {1'b0, div_eff};
    end

    always_ff @(posedge i_clk) begin
        if (r_dload) begin
            r_dq   <= mag[POS_W-1:0];
            r_rem  <= '0;
            r_dneg <= unwrap[DELTA_W-1];
        end else if (r_dcnt != '0) begin
            r_dq  <= {r_dq[POS_W-2:0], q_bit};
            r_rem <= q_bit ? DIV_W'(shifted - {1'b0, div_eff}) : shifted[DIV_W-1:0];
        end
    end

    // Signed quotient and saturating accumulate.
    always_comb begin
        quot = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        sum  = $signed({r_bal[BAL_W-1], r_bal})
             + $signed({{(BAL_W + 1 - QUOT_W){quot[QUOT_W-1]}}, quot});
        eff_limit = (r_limit > LIM_W'(REPORT_SLOTS)) ? LIM_W'(REPORT_SLOTS) : r_limit;
    end

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= RST_THRESHOLD;
            r_phold   <= RST_HOLD;
            r_div     <= RST_DIVISOR;
            r_limit   <= RST_LIMIT;
            r_kvld    <= '0;
            r_raddr   <= '0;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_dload   <= 1'b0;
            r_dcnt    <= '0;
            r_move    <= 1'b0;
            r_last    <= '0;
            r_bal     <= '0;
            r_hold    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_issue;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                    CFG_HOLD:      r_phold <= i_cfg_data[PHOLD_W-1:0];
                    CFG_DIVISOR:   r_div   <= i_cfg_data[DIV_W-1:0];
                    CFG_LIMIT:     r_limit <= i_cfg_data[LIM_W-1:0];
                    default:       r_thr   <= r_thr;
                endcase
            end

            if (o_in_ready && i_in_valid) begin
                r_raddr <= '0;
                r_count <= '0;
                r_dload <= 1'b1;
                r_move  <= i_in.encoder_position != r_last;
                r_last  <= i_in.encoder_position;
            end

            if (rd_issue) begin
                r_raddr <= r_raddr + KEY_CW'(1);
            end

            if (r_rd_vld) begin
                r_kvld[r_rd_idx] <= 1'b1;
                if (pressed && (r_count < FILL_W'(REPORT_SLOTS))) begin
                    r_count <= r_count + FILL_W'(1);
                end
            end

            if (r_dload) begin
                r_dload <= 1'b0;
                r_dcnt  <= DCNT_W'(POS_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end

            if (acc_act && r_move) begin
                if (sum > $signed((BAL_W + 1)'({1'b0, {(BAL_W - 1){1'b1}}}))) begin
                    r_bal <= {1'b0, {(BAL_W - 1){1'b1}}};
                end else if (sum < $signed({2'b11, {(BAL_W - 1){1'b0}}})) begin
                    r_bal <= {1'b1, {(BAL_W - 1){1'b0}}};
                end else begin
                    r_bal <= sum[BAL_W-1:0];
                end
            end

            // Pay out one unit of balance: key on for H frames, off for H
            // frames, then take the unit off the balance.
            if (pulse_act && (r_count < FILL_W'(eff_limit)) && (r_bal != '0)) begin
                if (r_hold < HOLD_W'(r_phold)) begin
                    r_hold  <= r_hold + HOLD_W'(1);
                    r_count <= r_count + FILL_W'(1);
                end else if (r_hold < {r_phold, 1'b0}) begin
                    r_hold <= r_hold + HOLD_W'(1);
                end else begin
                    r_hold <= '0;
                    r_bal  <= r_bal[BAL_W-1] ? r_bal + BAL_W'(1) : r_bal - BAL_W'(1);
                end
            end

            if (emit_act) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_contacts <= i_in.contact_bits;
            r_delta    <= $signed(DELTA_W'(i_in.encoder_position)) - $signed(DELTA_W'(r_last));
            for (int s = 0; s < OUT_FIELDS; s++) begin
                r_slots[s] <= '0;
            end
        end

        if (rd_issue) begin
            r_rd_idx <= raddr;
            r_rd_kv  <= r_kvld[raddr];
        end

        if (r_rd_vld && pressed && (r_count < FILL_W'(REPORT_SLOTS))) begin
            r_slots[r_count[SLOT_IDX_W-1:0]] <= key_code;
        end

        if (pulse_act && (r_count < FILL_W'(eff_limit)) && (r_bal != '0)
                && (r_hold < HOLD_W'(r_phold))) begin
            r_slots[r_count[SLOT_IDX_W-1:0]] <= r_bal[BAL_W-1] ? CODE_DOWN : CODE_UP;
        end

        if (emit_act) begin
            r_out.slot_0 <= r_slots[0];
            r_out.slot_1 <= r_slots[1];
            r_out.slot_2 <= r_slots[2];
            r_out.slot_3 <= r_slots[3];
            r_out.slot_4 <= r_slots[4];
            r_out.slot_5 <= r_slots[5];
            r_out.slot_6 <= r_slots[6];
            r_out.slot_7 <= r_slots[7];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The report never holds more keys than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FILL_W'(REPORT_SLOTS))
        else $error("report fill count exceeds slot count");

    // The pulser only runs once the divider has finished.
    a_div_before_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PULSE) |-> div_done)
        else $error("pulser reached with divider still busy");

    // The hold counter only moves in the pulser step.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_PULSE) |=> $stable(r_hold))
        else $error("hold counter changed outside the pulser step");

    // Memory read-backs only happen during the key walk.
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("counter read-back outside the key walk");

endmodule

`default_nettype wire

@@ tb/sv/kdr_report_checker.sv @@
`timescale 1ns / 100ps

module kdr_report_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  i_in_ready,
    input  kdr_pkg::t_frame                      i_in,
    input  wire                                  i_out_valid,
    input  wire                                  i_out_ready,
    input  kdr_pkg::t_report                     i_out,
    input  wire                                  i_cfg_we,
    input  wire [kdr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [kdr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    import kdr_pkg::*;

    localparam int BAL_HI = 2 ** (BAL_W - 1) - 1;
    localparam int BAL_LO = -(2 ** (BAL_W - 1));

    // Shadow copy of the registers.
    logic [THR_W-1:0]   thr_q;
    logic [PHOLD_W-1:0] hold_limit_q;
    logic [DIV_W-1:0]   div_q;
    logic [LIM_W-1:0]   lim_q;

    // Shadow copy of the block's state.
    logic [CNT_W-1:0]  press_cnt [KEY_COUNT];
    logic [POS_W-1:0]  last_pos;
    int                balance;
    logic [HOLD_W-1:0] hold_cnt;

    t_report expected_reports [$];
    int      mismatches = 0;

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Advances the shadow state by one scan frame and builds its key report.
    task automatic compute_report(input t_frame f, output t_report r);
        logic [SLOT_W-1:0]            slots [OUT_FIELDS];
        logic [OUT_FIELDS*SLOT_W-1:0] packed_slots;
        int                           fill;
        int                           limit;
        int                           delta;
        int                           step_div;
        int                           sum;
        fill = 0;
        for (int i = 0; i < OUT_FIELDS; i++) slots[i] = '0;

        for (int i = 0; i < KEY_COUNT; i++) begin
            if (f.contact_bits[i]) begin
                if (press_cnt[i] != {CNT_W{1'b1}}) press_cnt[i]++;
            end else begin
                press_cnt[i] = '0;
            end
        end

        for (int i = 0; i < KEY_COUNT; i++) begin
            if (press_cnt[i] > CNT_W'(thr_q)) begin
                press_cnt[i] = CNT_W'(thr_q) + 1'b1;
                if (fill < REPORT_SLOTS && fill < OUT_FIELDS) begin
                    slots[fill] = SLOT_W'(i + 1);
                    fill++;
                end
            end
        end

        if (f.encoder_position != last_pos) begin
            delta    = int'(f.encoder_position) - int'(last_pos);
            step_div = (div_q == '0) ? 1 : int'(div_q);
            if (delta > 65000) delta -= 65536;
            else if (delta < -65000) delta += 65536;
            last_pos = f.encoder_position;
            sum = balance + delta / step_div;
            if (sum > BAL_HI) sum = BAL_HI;
            if (sum < BAL_LO) sum = BAL_LO;
            balance = sum;
        end

        limit = (int'(lim_q) > REPORT_SLOTS) ? REPORT_SLOTS : int'(lim_q);
        if (fill < limit && balance != 0) begin
            if (int'(hold_cnt) < int'(hold_limit_q)) begin
                hold_cnt++;
                slots[fill] = (balance < 0) ? CODE_DOWN : CODE_UP;
                fill++;
            end else if (int'(hold_cnt) < 2 * int'(hold_limit_q)) begin
                hold_cnt++;
            end else begin
                if (balance < 0) balance++;
                else balance--;
                hold_cnt = '0;
            end
        end

        for (int i = 0; i < OUT_FIELDS; i++)
            packed_slots[(OUT_FIELDS-1-i)*SLOT_W +: SLOT_W] = slots[i];
        r = packed_slots;
    endtask

    always @(posedge i_clk) begin : monitor
        t_report                      want;
        logic [OUT_FIELDS*SLOT_W-1:0] got_v;
        logic [OUT_FIELDS*SLOT_W-1:0] want_v;
        if (!i_rst_n) begin
            thr_q        = RST_THRESHOLD;
            hold_limit_q = RST_HOLD;
            div_q        = RST_DIVISOR;
            lim_q        = RST_LIMIT;
            for (int i = 0; i < KEY_COUNT; i++) press_cnt[i] = '0;
            last_pos = '0;
            balance  = 0;
            hold_cnt = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: thr_q        = i_cfg_data[THR_W-1:0];
                    CFG_HOLD:      hold_limit_q = i_cfg_data[PHOLD_W-1:0];
                    CFG_DIVISOR:   div_q        = i_cfg_data[DIV_W-1:0];
                    CFG_LIMIT:     lim_q        = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                compute_report(i_in, want);
                expected_reports.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    note_mismatch("report arrived with no frame outstanding");
                end else begin
                    want   = expected_reports.pop_front();
                    got_v  = i_out;
                    want_v = want;
                    for (int i = 0; i < OUT_FIELDS; i++) begin
                        if (got_v[(OUT_FIELDS-1-i)*SLOT_W +: SLOT_W] !==
                            want_v[(OUT_FIELDS-1-i)*SLOT_W +: SLOT_W])
                            note_mismatch($sformatf("slot_%0d is %0d, expected %0d", i,
                                got_v[(OUT_FIELDS-1-i)*SLOT_W +: SLOT_W],
                                want_v[(OUT_FIELDS-1-i)*SLOT_W +: SLOT_W]));
                    end
                end
            end
        end
        o_outstanding <= expected_reports.size();
        o_mismatches  <= mismatches;
    end

endmodule

@@ tb/sv/tb_key_debounce_report_encoder_pulser.sv @@
`timescale 1ns / 100ps

// Top of the key scanner testbench. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the checker
// instance that sits beside the block and watches its channels.
module tb_key_debounce_report_encoder_pulser;
    import kdr_pkg::*;

    // Encoder motion styles used by the random phases.
    typedef enum int {
        ENC_STILL,
        ENC_WALK,
        ENC_WIDE
    } t_enc_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_frame                in_frame;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_report               out_report;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int reports_outstanding;

    // When set, neither side inserts idle cycles any more.
    logic quiet = 1'b0;

    // Contacts the simulated user is currently holding down, and the last
    // encoder position that was sent.
    logic [CONTACT_W-1:0] keys_down = 22'h000015;
    logic [POS_W-1:0]     cur_pos   = '0;

    int stall_left = 0;

    // 8 ns clock period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_debounce_report_encoder_pulser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_frame),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_report),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    kdr_report_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_frame),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_report),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatch_count),
        .o_outstanding (reports_outstanding)
    );

    // Report receiver. Ready drops in random bursts, chosen independently
    // of valid so that stalls land on every phase of the block's frame
    // processing. The burst start chance is low enough that long stretches
    // without any stall occur as well.
    always @(posedge clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Offers one scan frame and returns at the edge where it was taken.
    // Valid stays high on return so that a following item can be offered
    // back to back without valid ever dropping in between. All samples of
    // ready are taken right after the edge, before any update of that edge.
    task automatic send_frame(input logic [CONTACT_W-1:0] contacts,
                              input logic [POS_W-1:0] pos);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid                  <= 1'b1;
        in_frame.contact_bits     <= contacts;
        in_frame.encoder_position <= pos;
        cur_pos = pos;
        do @(posedge clk); while (!in_ready);
    endtask

    // Waits until every report the checker expects has come back. Each frame
    // yields exactly one report, so an empty expectation list means the
    // block is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_outstanding != 0);
    endtask

    // Writes all four registers on consecutive edges once the block is idle.
    task automatic apply_config(input int threshold, input int hold,
                                input int divisor, input int limit);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_THRESHOLD;
        cfg_data <= CFG_DATA_W'(threshold);
        @(posedge clk);
        cfg_idx  <= CFG_HOLD;
        cfg_data <= CFG_DATA_W'(hold);
        @(posedge clk);
        cfg_idx  <= CFG_DIVISOR;
        cfg_data <= CFG_DATA_W'(divisor);
        @(posedge clk);
        cfg_idx  <= CFG_LIMIT;
        cfg_data <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Picks the contacts for the next frame. Mostly the user holds a stable
    // set of keys that changes one key at a time, so counters get a chance to
    // climb past the threshold. Now and then the whole hand moves, a single
    // contact bounces for one frame, or a frame carries pure noise.
    function automatic logic [CONTACT_W-1:0] next_contacts(input int churn);
        logic [CONTACT_W-1:0] contacts;
        if ($urandom_range(0, churn) == 0)
            keys_down ^= CONTACT_W'(1) << $urandom_range(0, KEY_COUNT - 1);
        if ($urandom_range(0, 49) == 0) begin
            case ($urandom_range(0, 2))
                0:       keys_down = CONTACT_W'($urandom & $urandom & $urandom);
                1:       keys_down = CONTACT_W'($urandom);
                default: keys_down = '0;
            endcase
        end
        contacts = keys_down;
        if ($urandom_range(0, 19) == 0)
            contacts = CONTACT_W'($urandom);
        else if ($urandom_range(0, 9) == 0)
            contacts ^= CONTACT_W'(1) << $urandom_range(0, KEY_COUNT - 1);
        return contacts;
    endfunction

    // A run of random frames with a given style of encoder motion.
    task automatic random_phase(input int frames, input t_enc_mode enc_mode,
                                input int churn);
        logic [POS_W-1:0] pos;
        for (int n = 0; n < frames; n++) begin
            pos = cur_pos;
            case (enc_mode)
                ENC_STILL: begin
                    // Mostly parked, so the balance drains back to zero.
                    if ($urandom_range(0, 29) == 0)
                        pos = cur_pos + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
                end
                ENC_WALK: begin
                    pos = cur_pos + POS_W'(int'($urandom_range(0, 80)) - 40);
                end
                default: begin
                    // Jumps, including positions near both ends of the
                    // counter so that the unwrap limits are crossed often.
                    case ($urandom_range(0, 3))
                        0:       pos = POS_W'($urandom);
                        1:       pos = POS_W'($urandom_range(0, 600));
                        2:       pos = POS_W'(65535 - $urandom_range(0, 600));
                        default: pos = cur_pos + POS_W'(int'($urandom_range(0, 2000)) - 1000);
                    endcase
                end
            endcase
            send_frame(next_contacts(churn), pos);
        end
    endtask

    // Spins the encoder whole turns in one direction. Each turn takes three
    // frames: two half-turn steps inside the counter range and one short
    // step across the wrap point, so every turn adds a full 65536 counts to
    // the balance. Enough turns drive the balance into saturation.
    task automatic spin_encoder(input int turns, input bit forward);
        logic [POS_W-1:0] low_pos;
        logic [POS_W-1:0] mid_pos;
        logic [POS_W-1:0] high_pos;
        for (int t = 0; t < turns; t++) begin
            low_pos  = POS_W'($urandom_range(0, 200));
            mid_pos  = POS_W'($urandom_range(30000, 35000));
            high_pos = POS_W'(65535 - $urandom_range(0, 200));
            // The closing stretch of the run goes without idle cycles.
            if (!forward && t == turns - 70) quiet <= 1'b1;
            if (forward) begin
                send_frame(next_contacts(6), low_pos);
                send_frame(next_contacts(6), mid_pos);
                send_frame(next_contacts(6), high_pos);
            end else begin
                send_frame(next_contacts(6), high_pos);
                send_frame(next_contacts(6), mid_pos);
                send_frame(next_contacts(6), low_pos);
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_frame = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_THRESHOLD;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With a zero threshold a closed contact counts as
        // pressed on its first frame, and a one-frame hold makes every
        // encoder unit cost exactly three frames.
        apply_config(0, 1, 1, 8);
        send_frame(22'h000000, 16'd0);      // nothing closed, encoder parked
        send_frame(22'h3FFFFF, 16'd65000);  // all keys: report full; +65000 stays
        send_frame(22'h3FFFFF, 16'd0);      // -65000 stays, balance back to zero
        send_frame(22'h200001, 16'd65001);  // first and last key; unwraps to -535
        send_frame(22'h200001, 16'd0);      // -65001 unwraps to +535
        send_frame(22'h000001, 16'd65535);  // one step back across the wrap
        send_frame(22'h000001, 16'd65535);  // parked: unit paid out
        send_frame(22'h155555, 16'd0);      // one step forward, report already full
        send_frame(22'h2AAAAA, 16'd0);      // other half of the keys, still full
        send_frame(22'h000000, 16'd0);      // up key alone in the first slot
        send_frame(22'h000000, 16'd0);
        send_frame(22'h000000, 16'd0);
        send_frame(22'h0000FF, 16'd3);      // exactly eight keys, no room for encoder
        send_frame(22'h00007F, 16'd3);      // seven keys plus the encoder key
        send_frame(22'h200000, 16'd3);
        send_frame(22'h3FFFFF, 16'd3);
        send_frame(22'h000000, 16'd3);
        send_frame(22'h000000, 16'd3);
        send_frame(22'h000000, 16'd0);      // negative balance, but an off frame: no key

        // Random phases across a range of settings. The third one holds the
        // largest threshold and hold time, so nothing gets pressed and the
        // hold counter climbs; the fourth then lowers the hold time under
        // the running count, and also uses a zero divisor.
        apply_config(3, 2, 2, 8);
        random_phase(90, ENC_WALK, 8);
        apply_config(0, 0, 1, 15);          // zero hold: units vanish silently
        random_phase(80, ENC_WALK, 6);
        apply_config(1023, 16383, 31, 4);
        random_phase(40, ENC_WIDE, 10);
        apply_config(5, 1, 0, 9);
        random_phase(90, ENC_WIDE, 5);
        apply_config(2, 3, 16, 0);          // encoder key never appended
        random_phase(80, ENC_WALK, 6);
        apply_config(10, 200, 2, 8);
        random_phase(60, ENC_WALK, 12);
        apply_config(1, 4, 7, 12);
        random_phase(100, ENC_WIDE, 4);
        apply_config(0, 1, 3, 8);
        random_phase(100, ENC_STILL, 6);
        apply_config(7, 9, 1, 6);
        random_phase(80, ENC_WALK, 5);

        // Saturate the balance at the top and then at the bottom.
        apply_config(2, 1, 1, 8);
        spin_encoder(140, 1'b1);
        spin_encoder(270, 1'b0);

        // Let every report come home, then a margin well past the frame
        // latency in case the block produces anything it should not.
        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && reports_outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop, several times the length of the slowest correct run.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/kdr_pkg.sv
sv/key_debounce_report_encoder_pulser.sv
tb/sv/kdr_report_checker.sv
tb/sv/tb_key_debounce_report_encoder_pulser.sv
